// ----- rtl/core/kac_pkg.sv -----
// ----------------------------------------------------------------------------
// kac_pkg
// Shared codes, result type and a BCD clamp helper for the keypad alarm code controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kac_pkg;

    // Menu state codes
    localparam logic [3:0] ST_START    = 4'd0;
    localparam logic [3:0] ST_DISARMED = 4'd1;
    localparam logic [3:0] ST_ARMED    = 4'd2;
    localparam logic [3:0] ST_ENTRY    = 4'd3;
    localparam logic [3:0] ST_RELEASE  = 4'd4;
    localparam logic [3:0] ST_CHOICE   = 4'd5;
    localparam logic [3:0] ST_NEWCODE  = 4'd6;
    localparam logic [3:0] ST_NEWREL   = 4'd7;
    localparam logic [3:0] ST_OFFER    = 4'd8;

    // Key codes
    localparam logic [4:0] K_NONE = 5'd0;
    localparam logic [4:0] K_D0   = 5'd1;
    localparam logic [4:0] K_D9   = 5'd10;
    localparam logic [4:0] K_A    = 5'd11;
    localparam logic [4:0] K_B    = 5'd12;
    localparam logic [4:0] K_C    = 5'd13;
    localparam logic [4:0] K_D    = 5'd14;
    localparam logic [4:0] K_STAR = 5'd15;
    localparam logic [4:0] K_HASH = 5'd16;

    // Event codes
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_ARMED    = 3'd1;
    localparam logic [2:0] EV_DISARMED = 3'd2;
    localparam logic [2:0] EV_REJECT   = 3'd3;
    localparam logic [2:0] EV_NEWDIGIT = 3'd4;
    localparam logic [2:0] EV_OFFERED  = 3'd5;
    localparam logic [2:0] EV_ACCEPTED = 3'd6;
    localparam logic [2:0] EV_DIGIT    = 3'd7;

    // Entry purposes
    localparam logic [1:0] PUR_ARM    = 2'd0;
    localparam logic [1:0] PUR_NEW    = 2'd1;
    localparam logic [1:0] PUR_RANDOM = 2'd2;

    localparam logic [15:0] OFFER_RESET = 16'h4321;

    // One result item
    typedef struct packed {
        logic [15:0] offered_code;
        logic [2:0]  event_res;
        logic [2:0]  entry_count;
        logic [3:0]  menu_step_out;
        logic        armed;
    } t_result;

    // Clamp each BCD nibble to 9
    function automatic logic [15:0] sat_bcd(input logic [15:0] v);
        logic [15:0] r;
        r = v;
        for (int i = 0; i < 4; i++) begin
            if (v[4*i +: 4] > 4'd9) begin
                r[4*i +: 4] = 4'd9;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/kac_step.sv -----
// ----------------------------------------------------------------------------
// kac_step
// Next-state and event logic of the alarm menu for one keypad sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kac_step #(
    parameter int CODE_DIGITS = 4,
    parameter int PW          = 3
) (
    input  logic [4:0]       i_key,
    input  logic [15:0]      i_fresh,
    input  logic [3:0]       i_step,
    input  logic             i_armed,
    input  logic [1:0]       i_purpose,
    input  logic [PW-1:0]    i_pos,
    input  logic [3:0]       i_entered [CODE_DIGITS],
    input  logic [3:0]       i_stored  [CODE_DIGITS],
    input  logic [15:0]      i_offered,
    output logic [3:0]       o_step,
    output logic             o_armed,
    output logic [1:0]       o_purpose,
    output logic [PW-1:0]    o_pos,
    output logic [3:0]       o_entered [CODE_DIGITS],
    output logic [3:0]       o_stored  [CODE_DIGITS],
    output logic [15:0]      o_offered,
    output kac_pkg::t_result o_res
);
    import kac_pkg::*;

    logic          is_digit;
    logic [3:0]    digit;
    logic          match;
    logic          pos_full;
    logic [3:0]    main_step;
    logic [2:0]    ev;
    logic [31:0]   off_ext;
    logic [4:0]    key_m1;

    // Key decode and code compare
    always_comb begin
        is_digit  = (i_key >= K_D0) && (i_key <= K_D9);
        key_m1    = i_key - K_D0;
        digit     = is_digit ? key_m1[3:0] : 4'd0;
        pos_full  = (i_pos >= PW'(CODE_DIGITS));
        main_step = i_armed ? ST_ARMED : ST_DISARMED;
        off_ext   = {i_offered, 16'h0000};
        match     = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (i_entered[i] != i_stored[i]) begin
                match = 1'b0;
            end
        end
    end

    // Menu transition
    always_comb begin
        o_step    = i_step;
        o_armed   = i_armed;
        o_purpose = i_purpose;
        o_pos     = i_pos;
        o_entered = i_entered;
        o_stored  = i_stored;
        o_offered = i_offered;
        ev        = EV_NONE;
        unique case (i_step)
            ST_DISARMED: begin
                if (i_key == K_A) begin
                    o_step    = ST_ENTRY;
                    o_purpose = PUR_ARM;
                    o_pos     = '0;
                    for (int i = 0; i < CODE_DIGITS; i++) o_entered[i] = 4'd0;
                end else if (i_key == K_B) begin
                    o_step = ST_CHOICE;
                end
            end
            ST_ARMED: begin
                if (i_key == K_A) begin
                    o_step    = ST_ENTRY;
                    o_purpose = PUR_ARM;
                    o_pos     = '0;
                    for (int i = 0; i < CODE_DIGITS; i++) o_entered[i] = 4'd0;
                end
            end
            ST_ENTRY: begin
                if (i_key == K_C) begin
                    o_step = main_step;
                end else if (is_digit) begin
                    o_step = ST_RELEASE;
                    if (!pos_full) begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                            if (i_pos == PW'(i)) o_entered[i] = digit;
                        end
                        o_pos = i_pos + PW'(1);
                        ev    = EV_DIGIT;
                    end
                end else if (i_key == K_D) begin
                    if (i_purpose == PUR_ARM) begin
                        if (match) begin
                            o_armed = ~i_armed;
                            ev      = i_armed ? EV_DISARMED : EV_ARMED;
                            o_step  = i_armed ? ST_DISARMED : ST_ARMED;
                        end else begin
                            ev     = EV_REJECT;
                            o_step = main_step;
                        end
                    end else if (i_purpose == PUR_NEW) begin
                        if (match) begin
                            o_step = ST_NEWCODE;
                            o_pos  = '0;
                            for (int i = 0; i < CODE_DIGITS; i++) o_entered[i] = 4'd0;
                        end else begin
                            o_step = ST_CHOICE;
                            ev     = EV_REJECT;
                        end
                    end else if (i_purpose == PUR_RANDOM) begin
                        if (match) begin
                            o_offered = sat_bcd(i_fresh);
                            o_step    = ST_OFFER;
                            ev        = EV_OFFERED;
                        end else begin
                            o_step = ST_CHOICE;
                            ev     = EV_REJECT;
                        end
                    end
                end
            end
            ST_RELEASE: begin
                if (i_key == K_NONE) o_step = ST_ENTRY;
            end
            ST_CHOICE: begin
                if (i_key == K_C) begin
                    o_step = main_step;
                end else if (i_key == K_STAR || i_key == K_HASH) begin
                    o_step    = ST_ENTRY;
                    o_purpose = (i_key == K_STAR) ? PUR_NEW : PUR_RANDOM;
                    o_pos     = '0;
                    for (int i = 0; i < CODE_DIGITS; i++) o_entered[i] = 4'd0;
                end
            end
            ST_NEWCODE: begin
                if (i_key == K_C) begin
                    o_step = ST_DISARMED;
                end else if (is_digit) begin
                    if (pos_full) begin
                        o_step = ST_DISARMED;
                        o_pos  = '0;
                    end else begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                            if (i_pos == PW'(i)) o_stored[i] = digit;
                        end
                        o_pos  = i_pos + PW'(1);
                        o_step = ST_NEWREL;
                        ev     = EV_NEWDIGIT;
                    end
                end
            end
            ST_NEWREL: begin
                if (i_key == K_NONE) o_step = ST_NEWCODE;
            end
            ST_OFFER: begin
                if (i_key == K_HASH) begin
                    // digits past the fourth take zero
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        o_stored[i] = off_ext[31-4*i -: 4];
                    end
                    o_step = ST_DISARMED;
                    ev     = EV_ACCEPTED;
                end else if (i_key == K_C) begin
                    o_step = ST_DISARMED;
                end
            end
            default: begin
                // start and unused codes
                o_step = ST_DISARMED;
            end
        endcase
    end

    // Result item
    always_comb begin
        o_res.armed         = o_armed;
        o_res.menu_step_out = o_step;
        o_res.entry_count   = 3'(o_pos);
        o_res.event_res     = ev;
        o_res.offered_code  = o_offered;
    end

endmodule

// ----- rtl/core/keypad_alarm_code_controller.sv -----
// ----------------------------------------------------------------------------
// keypad_alarm_code_controller
// Path: an accepted sample is held in the input register, then passes the
// menu step into the result register once that register is empty or read.
// Throughput: one sample per cycle while the result side is ready; one input
// register and one result register, with the menu step between them, set it.
// Reset: synchronous active-low; menu at start, disarmed, stored code 1,2,3,4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_alarm_code_controller #(
    parameter int CODE_DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // key[4:0], fresh_code[20:5], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // armed, menu_step_out[4:1],
                                        // entry_count[7:5], event_res[10:8],
                                        // offered_code[26:11], zero fill
);
    import kac_pkg::*;

    localparam int PW = $clog2(CODE_DIGITS + 1);

    // Input stage
    logic        r_in_valid;
    logic [4:0]  r_key;
    logic [15:0] r_fresh;

    // Menu state
    logic [3:0]    r_step,    n_step;
    logic          r_armed,   n_armed;
    logic [1:0]    r_purpose, n_purpose;
    logic [PW-1:0] r_pos,     n_pos;
    logic [3:0]    r_entered [CODE_DIGITS];
    logic [3:0]    n_entered [CODE_DIGITS];
    logic [3:0]    r_stored  [CODE_DIGITS];
    logic [3:0]    n_stored  [CODE_DIGITS];
    logic [15:0]   r_offered, n_offered;

    // Result stage
    logic    r_out_valid;
    t_result r_res, n_res;

    logic advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    kac_step #(
        .CODE_DIGITS (CODE_DIGITS),
        .PW          (PW)
    ) u_step (
        .i_key     (r_key),
        .i_fresh   (r_fresh),
        .i_step    (r_step),
        .i_armed   (r_armed),
        .i_purpose (r_purpose),
        .i_pos     (r_pos),
        .i_entered (r_entered),
        .i_stored  (r_stored),
        .i_offered (r_offered),
        .o_step    (n_step),
        .o_armed   (n_armed),
        .o_purpose (n_purpose),
        .o_pos     (n_pos),
        .o_entered (n_entered),
        .o_stored  (n_stored),
        .o_offered (n_offered),
        .o_res     (n_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_key   <= s_axis_tdata[4:0];
            r_fresh <= s_axis_tdata[20:5];
        end
    end

    // State update, once per transfer through the step logic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_START;
            r_armed   <= 1'b0;
            r_purpose <= PUR_ARM;
            r_pos     <= '0;
            r_offered <= OFFER_RESET;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                r_entered[i] <= 4'd0;
                r_stored[i]  <= 4'((i + 1) % 10);
            end
        end else if (advance) begin
            r_step    <= n_step;
            r_armed   <= n_armed;
            r_purpose <= n_purpose;
            r_pos     <= n_pos;
            r_offered <= n_offered;
            r_entered <= n_entered;
            r_stored  <= n_stored;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_res};

endmodule

// ----- tb/keypad_alarm_code_controller_tb.sv -----
// ----------------------------------------------------------------------------
// keypad_alarm_code_controller_tb
// Drives keypad samples into the alarm menu controller over the input stream
// and checks every result transfer against a cycle-free model of the menu.
// A short directed walk covers offer, accept, saturation, reject and arming;
// the rest is random menu traffic steered toward well-formed code entries,
// with random gaps on both sides and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keypad_alarm_code_controller_tb;

    import kac_pkg::*;

    localparam int          DIGITS           = 4;
    localparam int          SINK_HOLD_CYCLES = 80;
    localparam int          TAIL_CYCLES      = 8;
    localparam int          MAX_REPORTS      = 10;
    localparam longint      RUN_LIMIT_NS     = 5_000_000;
    localparam logic [4:0]  K_UNUSED_TOP     = 5'd31;  // highest undefined key code

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // key[4:0], fresh_code[20:5], zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // armed, menu_step_out[4:1],
                                      // entry_count[7:5], event_res[10:8],
                                      // offered_code[26:11], zero fill

    // Menu model state
    logic [3:0]  mdl_step;
    logic        mdl_armed;
    logic [1:0]  mdl_purpose;
    logic [2:0]  mdl_pos;
    logic [3:0]  mdl_typed [DIGITS];
    logic [3:0]  mdl_code  [DIGITS];
    logic [15:0] mdl_offer;

    t_result     expected_menu_results [$];
    int          menu_mismatches = 0;
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    bit          sink_hold_req = 1'b0;

    keypad_alarm_code_controller #(
        .CODE_DIGITS(DIGITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Menu model
    // ------------------------------------------------------------------
    function automatic void reset_menu_model();
        mdl_step    = ST_START;
        mdl_armed   = 1'b0;
        mdl_purpose = PUR_ARM;
        mdl_pos     = '0;
        mdl_offer   = OFFER_RESET;
        for (int i = 0; i < DIGITS; i++) begin
            mdl_typed[i] = '0;
            mdl_code[i]  = 4'((i + 1) % 10);
        end
    endfunction

    function automatic void open_entry(input logic [1:0] purpose);
        mdl_step    = ST_ENTRY;
        mdl_purpose = purpose;
        mdl_pos     = '0;
        for (int i = 0; i < DIGITS; i++) mdl_typed[i] = '0;
    endfunction

    function automatic logic [3:0] home_step();
        return mdl_armed ? ST_ARMED : ST_DISARMED;
    endfunction

    // Advance the menu by one sample and return the result it shows
    function automatic t_result step_menu(input logic [4:0] key, input logic [15:0] fresh);
        t_result    r;
        logic       is_dig;
        logic [3:0] dig;
        logic [2:0] ev;
        logic       match;
        logic [3:0] nib;
        is_dig = (key >= K_D0) && (key <= K_D9);
        dig    = is_dig ? 4'(key - K_D0) : 4'd0;
        ev     = EV_NONE;
        match  = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (mdl_typed[i] != mdl_code[i]) match = 1'b0;
        end
        case (mdl_step)
            ST_DISARMED: begin
                if (key == K_A) open_entry(PUR_ARM);
                else if (key == K_B) mdl_step = ST_CHOICE;
            end
            ST_ARMED: begin
                if (key == K_A) open_entry(PUR_ARM);
            end
            ST_ENTRY: begin
                if (key == K_C) begin
                    mdl_step = home_step();
                end else if (is_dig) begin
                    mdl_step = ST_RELEASE;
                    if (mdl_pos < DIGITS) begin
                        mdl_typed[mdl_pos] = dig;
                        mdl_pos = mdl_pos + 3'd1;
                        ev = EV_DIGIT;
                    end
                end else if (key == K_D) begin
                    case (mdl_purpose)
                        PUR_ARM: begin
                            if (match) begin
                                mdl_armed = ~mdl_armed;
                                ev = mdl_armed ? EV_ARMED : EV_DISARMED;
                            end else begin
                                ev = EV_REJECT;
                            end
                            mdl_step = home_step();
                        end
                        PUR_NEW: begin
                            if (match) begin
                                mdl_step = ST_NEWCODE;
                                mdl_pos  = '0;
                                for (int i = 0; i < DIGITS; i++) mdl_typed[i] = '0;
                            end else begin
                                mdl_step = ST_CHOICE;
                                ev = EV_REJECT;
                            end
                        end
                        PUR_RANDOM: begin
                            if (match) begin
                                // digit 0 sits in the top nibble; clamp each to 9
                                for (int i = 0; i < 4; i++) begin
                                    nib = fresh[4*i +: 4];
                                    mdl_offer[4*i +: 4] = (nib > 4'd9) ? 4'd9 : nib;
                                end
                                mdl_step = ST_OFFER;
                                ev = EV_OFFERED;
                            end else begin
                                mdl_step = ST_CHOICE;
                                ev = EV_REJECT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RELEASE: begin
                if (key == K_NONE) mdl_step = ST_ENTRY;
            end
            ST_CHOICE: begin
                if (key == K_C) mdl_step = home_step();
                else if (key == K_STAR) open_entry(PUR_NEW);
                else if (key == K_HASH) open_entry(PUR_RANDOM);
            end
            ST_NEWCODE: begin
                if (key == K_C) begin
                    mdl_step = ST_DISARMED;
                end else if (is_dig) begin
                    if (mdl_pos >= DIGITS) begin
                        mdl_step = ST_DISARMED;
                        mdl_pos  = '0;
                    end else begin
                        mdl_code[mdl_pos] = dig;
                        mdl_pos  = mdl_pos + 3'd1;
                        mdl_step = ST_NEWREL;
                        ev = EV_NEWDIGIT;
                    end
                end
            end
            ST_NEWREL: begin
                if (key == K_NONE) mdl_step = ST_NEWCODE;
            end
            ST_OFFER: begin
                if (key == K_HASH) begin
                    for (int i = 0; i < DIGITS; i++) begin
                        mdl_code[i] = (i < 4) ? mdl_offer[12-4*i +: 4] : 4'd0;
                    end
                    mdl_step = ST_DISARMED;
                    ev = EV_ACCEPTED;
                end else if (key == K_C) begin
                    mdl_step = ST_DISARMED;
                end
            end
            default: mdl_step = ST_DISARMED;  // start and unused codes
        endcase
        r.armed         = mdl_armed;
        r.menu_step_out = mdl_step;
        r.entry_count   = mdl_pos;
        r.event_res     = ev;
        r.offered_code  = mdl_offer;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [4:0] any_key();
        return 5'($urandom_range(0, K_UNUSED_TOP));
    endfunction

    function automatic logic [4:0] any_digit_key();
        return 5'(K_D0 + $urandom_range(0, 9));
    endfunction

    function automatic logic [15:0] choose_fresh();
        logic [15:0] v;
        if ($urandom_range(0, 1) == 0) return 16'($urandom());
        for (int i = 0; i < 4; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
        return v;
    endfunction

    // Mostly keys that move the menu forward from its current state
    function automatic logic [4:0] choose_key();
        int r;
        logic [4:0] k;
        r = $urandom_range(0, 99);
        if (r < 8) return any_key();
        case (mdl_step)
            ST_DISARMED: k = (r < 50) ? K_A : (r < 88) ? K_B : any_key();
            ST_ARMED:    k = (r < 85) ? K_A : any_key();
            ST_ENTRY: begin
                if (mdl_pos < DIGITS) begin
                    if (r < 80)      k = 5'(K_D0 + mdl_code[mdl_pos]);
                    else if (r < 86) k = any_digit_key();
                    else if (r < 93) k = K_D;
                    else if (r < 96) k = K_C;
                    else             k = any_key();
                end else begin
                    if (r < 85)      k = K_D;
                    else if (r < 92) k = any_digit_key();
                    else             k = K_C;
                end
            end
            ST_RELEASE, ST_NEWREL: begin
                k = (r < 80) ? K_NONE : 5'($urandom_range(1, K_UNUSED_TOP));
            end
            ST_CHOICE:  k = (r < 48) ? K_STAR : (r < 92) ? K_HASH : K_C;
            ST_NEWCODE: k = (r < 88) ? any_digit_key() : (r < 93) ? K_C : any_key();
            ST_OFFER:   k = (r < 60) ? K_HASH : (r < 85) ? K_C : any_key();
            default:    k = any_key();
        endcase
        return k;
    endfunction

    // Offer one sample, wait for its transfer, record what it should show
    task automatic send_keypad_sample(input logic [4:0] key, input logic [15:0] fresh);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, fresh, key};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        expected_menu_results.push_back(step_menu(key, fresh));
        if (src_idle_en && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_menu_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Offer with saturated digits, accept, reject, arm on a short code, back out
    task automatic test_directed_menu();
        logic [4:0] walk [$];
        walk = '{K_NONE, K_B, K_HASH,
                 5'(K_D0 + 1), K_UNUSED_TOP, K_NONE,   // held in release
                 5'(K_D0 + 2), K_NONE, 5'(K_D0 + 3), K_NONE,
                 5'(K_D0 + 4), K_NONE,
                 5'(K_D0 + 5), K_NONE,                 // fifth digit not counted
                 K_D, K_HASH,                          // offer 9,0,0,0 then accept
                 K_A, K_D,                             // all-zero entry rejected
                 K_A, 5'(K_D0 + 9), K_NONE, K_D,       // untyped digits count as 0
                 K_A, K_C};
        foreach (walk[i]) send_keypad_sample(walk[i], 16'hA000);
        pause_until_drained();
    endtask

    task automatic test_random_menu(input int count, input bit idle);
        src_idle_en  = idle;
        sink_idle_en = idle;
        repeat (count) send_keypad_sample(choose_key(), choose_fresh());
        pause_until_drained();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Output held off while input keeps coming; block must stall its input
    task automatic test_output_stall();
        src_idle_en   = 1'b0;
        sink_hold_req = 1'b1;
        repeat (60) send_keypad_sample(choose_key(), choose_fresh());
        pause_until_drained();
        src_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and checker
    // ------------------------------------------------------------------
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (int n = 0; n < SINK_HOLD_CYCLES; n++) @(posedge i_clk);
            end else if (!sink_idle_en || $urandom_range(0, 99) < 70) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
        end
    end

    function automatic void note_failure(input string msg);
        menu_mismatches++;
        if (menu_mismatches <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got = m_axis_tdata[26:0];
            if (expected_menu_results.size() == 0) begin
                note_failure($sformatf("unexpected result transfer: tdata=%h", m_axis_tdata));
            end else begin
                want = expected_menu_results.pop_front();
                if (got !== want || m_axis_tdata[31:27] !== 5'd0) begin
                    note_failure($sformatf(
                        {"mismatch at %0t: armed %0d/%0d step %0d/%0d count %0d/%0d ",
                         "event %0d/%0d offer %h/%h fill %0d (exp/got)"},
                        $realtime, want.armed, got.armed,
                        want.menu_step_out, got.menu_step_out,
                        want.entry_count, got.entry_count,
                        want.event_res, got.event_res,
                        want.offered_code, got.offered_code, m_axis_tdata[31:27]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        reset_menu_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_menu();
        test_random_menu(900, 1'b1);
        test_random_menu(300, 1'b0);
        test_output_stall();
        test_random_menu(600, 1'b1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_menu_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", expected_menu_results.size()));
        end
        if (menu_mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
